// File: rtl/cbpg_pkg.sv
// Shared types, register codes and color tables for the color bar pattern generator.
package cbpg_pkg;

  // Pixel format codes
  typedef enum logic [3:0] {
    FMT_RGB565   = 4'd0,
    FMT_BGR565   = 4'd1,
    FMT_RGB565LE = 4'd2,
    FMT_BGR565LE = 4'd3,
    FMT_RGB888   = 4'd4,
    FMT_BGR888   = 4'd5,
    FMT_ARGB8888 = 4'd6,
    FMT_ABGR8888 = 4'd7,
    FMT_BGRA8888 = 4'd8,
    FMT_ARGB4444 = 4'd9,
    FMT_ABGR4444 = 4'd10,
    FMT_ARGB1555 = 4'd11,
    FMT_ABGR1555 = 4'd12,
    FMT_MONO8    = 4'd13
  } pix_fmt_t;

  // Configuration register indexes
  localparam logic [1:0] REG_OUT_FORMAT   = 2'd0;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam int unsigned CFG_DW = 13;
  localparam logic [CFG_DW-1:0] RST_FRAME_WIDTH  = 13'd480;
  localparam logic [CFG_DW-1:0] RST_FRAME_HEIGHT = 13'd800;

  // Color index: 0..7 bars, 8 border
  typedef logic [3:0] color_idx_t;
  localparam color_idx_t BORDER_IDX = 4'd8;
  localparam int unsigned NUM_COLORS = 9;

  // Tables listed from the border entry (index 8) down to bar 0
  localparam logic [NUM_COLORS-1:0][7:0] BAR_R = {8'd255, 8'd0, 8'd0, 8'd255, 8'd255,
                                                  8'd0, 8'd0, 8'd255, 8'd255};
  localparam logic [NUM_COLORS-1:0][7:0] BAR_G = {8'd128, 8'd0, 8'd0, 8'd0, 8'd0,
                                                  8'd255, 8'd255, 8'd255, 8'd255};
  localparam logic [NUM_COLORS-1:0][7:0] BAR_B = {8'd0, 8'd0, 8'd255, 8'd0, 8'd255,
                                                  8'd0, 8'd255, 8'd0, 8'd255};
  localparam logic [NUM_COLORS-1:0][7:0] GREY  = {8'd220, 8'd40, 8'd70, 8'd100, 8'd130,
                                                  8'd160, 8'd190, 8'd220, 8'd255};

  // Four bytes in memory order plus count
  typedef struct packed {
    logic [2:0] byte_count;
    logic [7:0] byte_fourth;
    logic [7:0] byte_third;
    logic [7:0] byte_second;
    logic [7:0] byte_first;
  } pix_bytes_t;

  function automatic logic [15:0] pack565(input logic [7:0] hi_c, input logic [7:0] g,
                                          input logic [7:0] lo_c);
    return {hi_c[7:3], g[7:2], lo_c[7:3]};
  endfunction

  function automatic logic [15:0] pack4444(input logic [7:0] hi_c, input logic [7:0] g,
                                           input logic [7:0] lo_c);
    return {4'hF, hi_c[7:4], g[7:4], lo_c[7:4]};
  endfunction

  function automatic logic [15:0] pack1555(input logic [7:0] hi_c, input logic [7:0] g,
                                           input logic [7:0] lo_c);
    return {1'b1, hi_c[7:3], g[7:3], lo_c[7:3]};
  endfunction

endpackage

// File: rtl/cbpg_bar_index.sv
// Two pipeline stages: border test and bar index by compare against multiples of inner width.
module cbpg_bar_index #(
  parameter int unsigned MAX_SIDE = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [11:0]                   pos_x,
  input  logic [11:0]                   pos_y,
  input  logic [cbpg_pkg::CFG_DW-1:0]   frame_width,
  input  logic [cbpg_pkg::CFG_DW-1:0]   frame_height,
  output logic                          out_valid,
  output cbpg_pkg::color_idx_t          color_idx
);

  localparam int unsigned SW = $clog2(MAX_SIDE + 1);
  localparam int unsigned LW = (SW > cbpg_pkg::CFG_DW) ? SW : cbpg_pkg::CFG_DW;
  localparam int unsigned AW = ((SW > 12) ? SW : 12) + 1;
  localparam int unsigned PW = AW + 3;
  localparam int unsigned NUM_BARS = 8;

  logic [LW-1:0] fw_l, fh_l, w_sat, h_sat;
  logic [AW-1:0] w_a, h_a, x_a, y_a, inner;
  logic [2:0]    border;
  logic          interior;

  // Stage 1 registers
  logic          s1_valid;
  logic          s1_interior;
  logic [PW-1:0] s1_rel8;
  logic [PW-1:0] s1_inner;

  // Frame size saturation, border width, interior test and inner width
  always_comb begin
    fw_l  = LW'(frame_width);
    fh_l  = LW'(frame_height);
    w_sat = (fw_l > LW'(MAX_SIDE)) ? LW'(MAX_SIDE) : fw_l;
    h_sat = (fh_l > LW'(MAX_SIDE)) ? LW'(MAX_SIDE) : fh_l;
    w_a   = AW'(w_sat);
    h_a   = AW'(h_sat);
    x_a   = AW'(pos_x);
    y_a   = AW'(pos_y);
    border = (w_a >= AW'(32) && h_a >= AW'(32)) ? 3'd4 : 3'd2;
    interior = !(x_a < AW'(border) || (x_a + AW'(border)) >= w_a ||
                 y_a < AW'(border) || (y_a + AW'(border)) >= h_a);
    inner = (w_a > AW'({border, 1'b0})) ? (w_a - AW'({border, 1'b0})) : w_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_interior <= interior;
      s1_rel8     <= {x_a - AW'(border), 3'b000};
      s1_inner    <= PW'(inner);
    end
  end

  // Stage 2: count bar boundaries at or below rel_x*8
  logic [PW-1:0] mult [1:NUM_BARS-1];
  logic [2:0]    bar_cnt;

  always_comb begin
    bar_cnt = 3'd0;
    for (int k = 1; k < NUM_BARS; k++) begin
      mult[k] = s1_inner * PW'(k);
      bar_cnt = bar_cnt + 3'((s1_rel8 >= mult[k]) ? 1 : 0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      color_idx <= s1_interior ? cbpg_pkg::color_idx_t'(bar_cnt) : cbpg_pkg::BORDER_IDX;
    end
  end

endmodule

// File: rtl/cbpg_encoder.sv
// Output stage: color lookup and pixel format encoding into the output register.
module cbpg_encoder (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  cbpg_pkg::color_idx_t   color_idx,
  input  cbpg_pkg::pix_fmt_t     out_format,
  output logic                   out_valid,
  output cbpg_pkg::pix_bytes_t   pix
);

  logic [7:0]           r, g, b;
  logic [15:0]          v16;
  cbpg_pkg::pix_bytes_t enc;

  always_comb begin
    r   = cbpg_pkg::BAR_R[color_idx];
    g   = cbpg_pkg::BAR_G[color_idx];
    b   = cbpg_pkg::BAR_B[color_idx];
    v16 = 16'd0;
    enc = '0;
    enc.byte_count = 3'd4;
    case (out_format)
      cbpg_pkg::FMT_RGB565: begin
        v16 = cbpg_pkg::pack565(r, g, b);
        enc.byte_first  = v16[15:8];
        enc.byte_second = v16[7:0];
        enc.byte_count  = 3'd2;
      end
      cbpg_pkg::FMT_BGR565: begin
        v16 = cbpg_pkg::pack565(b, g, r);
        enc.byte_first  = v16[15:8];
        enc.byte_second = v16[7:0];
        enc.byte_count  = 3'd2;
      end
      cbpg_pkg::FMT_RGB565LE: begin
        v16 = cbpg_pkg::pack565(r, g, b);
        enc.byte_first  = v16[7:0];
        enc.byte_second = v16[15:8];
        enc.byte_count  = 3'd2;
      end
      cbpg_pkg::FMT_BGR565LE: begin
        v16 = cbpg_pkg::pack565(b, g, r);
        enc.byte_first  = v16[7:0];
        enc.byte_second = v16[15:8];
        enc.byte_count  = 3'd2;
      end
      cbpg_pkg::FMT_RGB888: begin
        enc.byte_first  = r;
        enc.byte_second = g;
        enc.byte_third  = b;
        enc.byte_count  = 3'd3;
      end
      cbpg_pkg::FMT_BGR888: begin
        enc.byte_first  = b;
        enc.byte_second = g;
        enc.byte_third  = r;
        enc.byte_count  = 3'd3;
      end
      cbpg_pkg::FMT_ARGB8888: begin
        enc.byte_first  = b;
        enc.byte_second = g;
        enc.byte_third  = r;
        enc.byte_fourth = 8'hFF;
      end
      cbpg_pkg::FMT_ABGR8888: begin
        enc.byte_first  = r;
        enc.byte_second = g;
        enc.byte_third  = b;
        enc.byte_fourth = 8'hFF;
      end
      cbpg_pkg::FMT_BGRA8888: begin
        enc.byte_first  = 8'hFF;
        enc.byte_second = r;
        enc.byte_third  = g;
        enc.byte_fourth = b;
      end
      cbpg_pkg::FMT_ARGB4444: begin
        v16 = cbpg_pkg::pack4444(r, g, b);
        enc.byte_first  = v16[7:0];
        enc.byte_second = v16[15:8];
        enc.byte_count  = 3'd2;
      end
      cbpg_pkg::FMT_ABGR4444: begin
        v16 = cbpg_pkg::pack4444(b, g, r);
        enc.byte_first  = v16[7:0];
        enc.byte_second = v16[15:8];
        enc.byte_count  = 3'd2;
      end
      cbpg_pkg::FMT_ARGB1555: begin
        v16 = cbpg_pkg::pack1555(r, g, b);
        enc.byte_first  = v16[7:0];
        enc.byte_second = v16[15:8];
        enc.byte_count  = 3'd2;
      end
      cbpg_pkg::FMT_ABGR1555: begin
        v16 = cbpg_pkg::pack1555(b, g, r);
        enc.byte_first  = v16[7:0];
        enc.byte_second = v16[15:8];
        enc.byte_count  = 3'd2;
      end
      cbpg_pkg::FMT_MONO8: begin
        enc.byte_first = cbpg_pkg::GREY[color_idx];
        enc.byte_count = 3'd1;
      end
      default: begin
        // unknown code: four zero bytes
        enc.byte_count = 3'd4;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix <= enc;
    end
  end

endmodule

// File: rtl/color_bar_pattern_generator_unit.sv
// Throughput: one pixel per clock while the output is free or taken; four register stages
// (input, border test, bar compare, format encode) all advance together.
// Reset: synchronous rst clears all stage valid bits and loads out_format 0,
// frame_width 480, frame_height 800.
module color_bar_pattern_generator_unit #(
  parameter int unsigned MAX_SIDE = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [23:0]                 s_tdata,   // pos_x[11:0], pos_y[23:12]
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [39:0]                 m_tdata,   // byte_first, byte_second, byte_third,
                                                 // byte_fourth, byte_count[34:32], zero pad
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [cbpg_pkg::CFG_DW-1:0] cfg_data
);

  cbpg_pkg::pix_fmt_t          out_format;
  logic [cbpg_pkg::CFG_DW-1:0] frame_width;
  logic [cbpg_pkg::CFG_DW-1:0] frame_height;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_format   <= cbpg_pkg::FMT_RGB565;
      frame_width  <= cbpg_pkg::RST_FRAME_WIDTH;
      frame_height <= cbpg_pkg::RST_FRAME_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        cbpg_pkg::REG_OUT_FORMAT:   out_format   <= cbpg_pkg::pix_fmt_t'(cfg_data[3:0]);
        cbpg_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        cbpg_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Whole pipeline moves when the output register is empty or being taken
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Input stage
  logic        s0_valid;
  logic [11:0] s0_x, s0_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_x <= s_tdata[11:0];
      s0_y <= s_tdata[23:12];
    end
  end

  logic                 idx_valid;
  cbpg_pkg::color_idx_t color_idx;

  cbpg_bar_index #(
    .MAX_SIDE(MAX_SIDE)
  ) u_bar_index (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (s0_valid),
    .pos_x        (s0_x),
    .pos_y        (s0_y),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .out_valid    (idx_valid),
    .color_idx    (color_idx)
  );

  cbpg_pkg::pix_bytes_t pix;

  cbpg_encoder u_encoder (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (idx_valid),
    .color_idx    (color_idx),
    .out_format   (out_format),
    .out_valid    (m_tvalid),
    .pix          (pix)
  );

  assign m_tdata = {5'd0, pix};

endmodule

// File: dv/tb_color_bar_pattern_generator_unit.sv
// Self-checking testbench for the color bar pattern generator: pixel stream against a predictor.
`timescale 1ns / 100ps

module tb_color_bar_pattern_generator_unit;

  localparam int unsigned MAX_SIDE_PX  = 4096;
  localparam int unsigned IDLE_PCT     = 18;
  localparam int unsigned DRAIN_CYCLES = 8;      // pipeline is 4 deep
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned RANDOM_ITEMS = 1800;

  // Format codes with no encoding, and the register index with no register
  localparam logic [3:0] FMT_RSVD_E = 4'd14;
  localparam logic [3:0] FMT_RSVD_F = 4'd15;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam logic [12:0] RST_W = cbpg_pkg::RST_FRAME_WIDTH;
  localparam logic [12:0] RST_H = cbpg_pkg::RST_FRAME_HEIGHT;

  // Results that can be read straight off the pattern definition
  localparam cbpg_pkg::pix_bytes_t BORDER_RGB565 = {3'd2, 8'h00, 8'h00, 8'h00, 8'hFC};
  localparam cbpg_pkg::pix_bytes_t BORDER_RGB888 = {3'd3, 8'h00, 8'h00, 8'h80, 8'hFF};
  localparam cbpg_pkg::pix_bytes_t BORDER_MONO8  = {3'd1, 8'h00, 8'h00, 8'h00, 8'd220};
  localparam cbpg_pkg::pix_bytes_t UNKNOWN_FMT   = {3'd4, 32'h0};

  typedef struct {
    logic [3:0]           fmt;
    logic [12:0]          wd;
    logic [12:0]          ht;
    logic [11:0]          px;
    logic [11:0]          py;
    bit                   typed;
    cbpg_pkg::pix_bytes_t want;
  } pixel_row_t;

  // Directed pixels; rows with typed = 0 go through the predictor
  pixel_row_t directed_rows [26] = '{
    '{cbpg_pkg::FMT_RGB565,   RST_W, RST_H, 12'd0,    12'd0,    1'b1, BORDER_RGB565},
    '{cbpg_pkg::FMT_RGB565,   RST_W, RST_H, 12'd4095, 12'd4095, 1'b1, BORDER_RGB565},
    '{cbpg_pkg::FMT_RGB565,   RST_W, RST_H, 12'd4,    12'd4,    1'b0, '0},
    '{cbpg_pkg::FMT_RGB565,   RST_W, RST_H, 12'd475,  12'd795,  1'b0, '0},
    '{cbpg_pkg::FMT_RGB565,   RST_W, RST_H, 12'd476,  12'd400,  1'b0, '0},
    '{cbpg_pkg::FMT_BGR565,   RST_W, RST_H, 12'd60,   12'd400,  1'b0, '0},
    '{cbpg_pkg::FMT_RGB565LE, RST_W, RST_H, 12'd120,  12'd400,  1'b0, '0},
    '{cbpg_pkg::FMT_BGR565LE, RST_W, RST_H, 12'd180,  12'd400,  1'b0, '0},
    '{cbpg_pkg::FMT_RGB888,   RST_W, RST_H, 12'd240,  12'd400,  1'b0, '0},
    '{cbpg_pkg::FMT_BGR888,   RST_W, RST_H, 12'd300,  12'd400,  1'b0, '0},
    '{cbpg_pkg::FMT_ARGB8888, RST_W, RST_H, 12'd360,  12'd400,  1'b0, '0},
    '{cbpg_pkg::FMT_ABGR8888, RST_W, RST_H, 12'd420,  12'd400,  1'b0, '0},
    '{cbpg_pkg::FMT_BGRA8888, RST_W, RST_H, 12'd470,  12'd400,  1'b0, '0},
    '{cbpg_pkg::FMT_ARGB4444, RST_W, RST_H, 12'd10,   12'd400,  1'b0, '0},
    '{cbpg_pkg::FMT_ABGR4444, RST_W, RST_H, 12'd70,   12'd400,  1'b0, '0},
    '{cbpg_pkg::FMT_ARGB1555, RST_W, RST_H, 12'd130,  12'd400,  1'b0, '0},
    '{cbpg_pkg::FMT_ABGR1555, RST_W, RST_H, 12'd190,  12'd400,  1'b0, '0},
    '{cbpg_pkg::FMT_MONO8,    RST_W, RST_H, 12'd250,  12'd400,  1'b0, '0},
    '{cbpg_pkg::FMT_MONO8,    RST_W, RST_H, 12'd0,    12'd5,    1'b1, BORDER_MONO8},
    '{FMT_RSVD_E,             RST_W, RST_H, 12'd100,  12'd100,  1'b1, UNKNOWN_FMT},
    '{FMT_RSVD_F,             RST_W, RST_H, 12'd100,  12'd100,  1'b1, UNKNOWN_FMT},
    '{cbpg_pkg::FMT_ARGB8888, 13'd8191, 13'd8191, 12'd4090, 12'd100, 1'b0, '0},
    '{cbpg_pkg::FMT_ARGB8888, 13'd8191, 13'd8191, 12'd4095, 12'd100, 1'b0, '0},
    '{cbpg_pkg::FMT_RGB888,   13'd0,    13'd0,    12'd10,   12'd10,  1'b1, BORDER_RGB888},
    '{cbpg_pkg::FMT_RGB888,   13'd31,   13'd40,   12'd2,    12'd2,   1'b0, '0},
    '{cbpg_pkg::FMT_RGB888,   13'd1,    13'd1,    12'd0,    12'd0,   1'b0, '0}
  };

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [23:0]                 s_tdata = '0;   // pos_x[11:0], pos_y[23:12]
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [39:0]                 m_tdata;        // byte_first, byte_second, byte_third,
                                               // byte_fourth, byte_count[34:32], zero pad
  logic                        cfg_we = 1'b0;
  logic [1:0]                  cfg_index = '0;
  logic [cbpg_pkg::CFG_DW-1:0] cfg_data = '0;

  // Expected bytes for a typed row travel alongside the input word
  logic                        typed_check = 1'b0;
  logic [34:0]                 typed_bytes = '0;

  // Shadow of the block's registers
  logic [3:0]                  cur_fmt = cbpg_pkg::FMT_RGB565;
  logic [12:0]                 cur_width = RST_W;
  logic [12:0]                 cur_height = RST_H;

  cbpg_pkg::pix_bytes_t        pending_pixels [$];
  int unsigned                 mismatches = 0;
  int unsigned                 stall_cycles = 0;
  bit                          calm = 1'b0;

  color_bar_pattern_generator_unit #(.MAX_SIDE(MAX_SIDE_PX)) u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bytes of the test pattern at one position under the current registers
  function automatic cbpg_pkg::pix_bytes_t color_bar_bytes(input logic [11:0] x,
                                                           input logic [11:0] y);
    int unsigned          w, h, bd, inner, bar, xi, yi;
    logic [3:0]           ci;
    logic [7:0]           r, g, b;
    logic [15:0]          half;
    cbpg_pkg::pix_bytes_t o;
    xi = 32'(x);
    yi = 32'(y);
    w = (32'(cur_width) > MAX_SIDE_PX) ? MAX_SIDE_PX : 32'(cur_width);
    h = (32'(cur_height) > MAX_SIDE_PX) ? MAX_SIDE_PX : 32'(cur_height);
    bd = (w >= 32 && h >= 32) ? 4 : 2;
    ci = cbpg_pkg::BORDER_IDX;
    if (!(xi < bd || xi + bd >= w || yi < bd || yi + bd >= h)) begin
      inner = (w > 2 * bd) ? w - 2 * bd : w;
      bar = (inner != 0) ? ((xi - bd) * 8) / inner : 7;
      ci = (bar > 7) ? 4'd7 : bar[3:0];
    end
    r = cbpg_pkg::BAR_R[ci];
    g = cbpg_pkg::BAR_G[ci];
    b = cbpg_pkg::BAR_B[ci];
    o = '0;
    case (cur_fmt)
      cbpg_pkg::FMT_RGB565, cbpg_pkg::FMT_BGR565,
      cbpg_pkg::FMT_RGB565LE, cbpg_pkg::FMT_BGR565LE: begin
        if (cur_fmt == cbpg_pkg::FMT_BGR565 || cur_fmt == cbpg_pkg::FMT_BGR565LE)
          half = {b[7:3], g[7:2], r[7:3]};
        else
          half = {r[7:3], g[7:2], b[7:3]};
        if (cur_fmt == cbpg_pkg::FMT_RGB565LE || cur_fmt == cbpg_pkg::FMT_BGR565LE)
          {o.byte_second, o.byte_first} = half;
        else
          {o.byte_first, o.byte_second} = half;
        o.byte_count = 3'd2;
      end
      cbpg_pkg::FMT_RGB888: begin
        {o.byte_third, o.byte_second, o.byte_first} = {b, g, r};
        o.byte_count = 3'd3;
      end
      cbpg_pkg::FMT_BGR888: begin
        {o.byte_third, o.byte_second, o.byte_first} = {r, g, b};
        o.byte_count = 3'd3;
      end
      cbpg_pkg::FMT_ARGB8888: begin
        {o.byte_fourth, o.byte_third, o.byte_second, o.byte_first} = {8'hFF, r, g, b};
        o.byte_count = 3'd4;
      end
      cbpg_pkg::FMT_ABGR8888: begin
        {o.byte_fourth, o.byte_third, o.byte_second, o.byte_first} = {8'hFF, b, g, r};
        o.byte_count = 3'd4;
      end
      cbpg_pkg::FMT_BGRA8888: begin
        {o.byte_fourth, o.byte_third, o.byte_second, o.byte_first} = {b, g, r, 8'hFF};
        o.byte_count = 3'd4;
      end
      cbpg_pkg::FMT_ARGB4444: begin
        {o.byte_second, o.byte_first} = {4'hF, r[7:4], g[7:4], b[7:4]};
        o.byte_count = 3'd2;
      end
      cbpg_pkg::FMT_ABGR4444: begin
        {o.byte_second, o.byte_first} = {4'hF, b[7:4], g[7:4], r[7:4]};
        o.byte_count = 3'd2;
      end
      cbpg_pkg::FMT_ARGB1555: begin
        {o.byte_second, o.byte_first} = {1'b1, r[7:3], g[7:3], b[7:3]};
        o.byte_count = 3'd2;
      end
      cbpg_pkg::FMT_ABGR1555: begin
        {o.byte_second, o.byte_first} = {1'b1, b[7:3], g[7:3], r[7:3]};
        o.byte_count = 3'd2;
      end
      cbpg_pkg::FMT_MONO8: begin
        o.byte_first = cbpg_pkg::GREY[ci];
        o.byte_count = 3'd1;
      end
      default: begin
        o.byte_count = 3'd4;
      end
    endcase
    return o;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("ERROR @%0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Leaves cfg_we high; the caller lowers it after the last write
  task automatic write_reg(input logic [1:0] idx, input logic [cbpg_pkg::CFG_DW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      cbpg_pkg::REG_OUT_FORMAT:   cur_fmt = val[3:0];
      cbpg_pkg::REG_FRAME_WIDTH:  cur_width = val;
      cbpg_pkg::REG_FRAME_HEIGHT: cur_height = val;
      default: ;
    endcase
  endtask

  task automatic load_setup(input logic [3:0] fmt, input logic [12:0] wd,
                            input logic [12:0] ht, input bit poke_unused);
    write_reg(cbpg_pkg::REG_OUT_FORMAT, {9'd0, fmt});
    write_reg(cbpg_pkg::REG_FRAME_WIDTH, wd);
    write_reg(cbpg_pkg::REG_FRAME_HEIGHT, ht);
    if (poke_unused)
      write_reg(REG_UNUSED, cbpg_pkg::CFG_DW'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Stop sending and let every word in flight come out
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_pixel(input logic [11:0] x, input logic [11:0] y, input bit typed,
                            input cbpg_pkg::pix_bytes_t want);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {y, x};
    typed_check <= typed;
    typed_bytes <= want;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
  endtask

  function automatic logic [12:0] pick_side();
    case ($urandom_range(0, 9))
      0: return 13'($urandom_range(1, 31));
      1: begin
        case ($urandom_range(0, 3))
          0: return 13'd0;
          1: return 13'd1;
          2: return 13'd4096;
          default: return 13'd8191;
        endcase
      end
      2: return 13'($urandom_range(4097, 8191));
      3: return 13'($urandom_range(1025, 4096));
      default: return 13'($urandom_range(32, 1024));
    endcase
  endfunction

  // Mostly inside the frame, often near its edges, sometimes anywhere
  function automatic logic [11:0] pick_coord(input logic [12:0] side);
    int unsigned lim, lo;
    lim = (32'(side) > MAX_SIDE_PX) ? MAX_SIDE_PX : 32'(side);
    if (lim == 0 || $urandom_range(0, 7) == 0)
      return 12'($urandom_range(0, 4095));
    lo = (lim > 6) ? lim - 6 : 0;
    case ($urandom_range(0, 7))
      0: return 12'($urandom_range(0, (lim > 6) ? 5 : lim - 1));
      1: return 12'($urandom_range(lo, lim - 1));
      default: return 12'($urandom_range(0, lim - 1));
    endcase
  endfunction

  // Scoreboard, output stalls and watchdog
  always @(posedge clk) begin : monitor
    cbpg_pkg::pix_bytes_t got, want;
    m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    if (!rst && s_tvalid && s_tready)
      pending_pixels.push_back(typed_check ? cbpg_pkg::pix_bytes_t'(typed_bytes)
                                           : color_bar_bytes(s_tdata[11:0], s_tdata[23:12]));
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[34:0];
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected word", got[31:0], 0);
      end else begin
        want = pending_pixels.pop_front();
        if (got.byte_first !== want.byte_first)
          report_mismatch("byte_first", 32'(got.byte_first), 32'(want.byte_first));
        if (got.byte_second !== want.byte_second)
          report_mismatch("byte_second", 32'(got.byte_second), 32'(want.byte_second));
        if (got.byte_third !== want.byte_third)
          report_mismatch("byte_third", 32'(got.byte_third), 32'(want.byte_third));
        if (got.byte_fourth !== want.byte_fourth)
          report_mismatch("byte_fourth", 32'(got.byte_fourth), 32'(want.byte_fourth));
        if (got.byte_count !== want.byte_count)
          report_mismatch("byte_count", 32'(got.byte_count), 32'(want.byte_count));
      end
    end
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("color_bar_pattern_generator_unit test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned phase_no;
    int unsigned n;
    logic [3:0]  fmt;
    logic [12:0] wd, ht;
    sent = 0;
    phase_no = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows; registers change only when the row asks for another setting
    for (int i = 0; i < $size(directed_rows); i++) begin
      if (directed_rows[i].fmt != cur_fmt || directed_rows[i].wd != cur_width ||
          directed_rows[i].ht != cur_height) begin
        wait_idle();
        load_setup(directed_rows[i].fmt, directed_rows[i].wd, directed_rows[i].ht, 1'b0);
      end
      send_pixel(directed_rows[i].px, directed_rows[i].py, directed_rows[i].typed,
                 directed_rows[i].want);
    end

    // Random phases, each with its own format and frame size
    while (sent < RANDOM_ITEMS) begin
      calm = (phase_no == 3);
      n = calm ? 300 : $urandom_range(40, 160);
      fmt = 4'($urandom_range(0, 15));
      wd = pick_side();
      ht = pick_side();
      wait_idle();
      load_setup(fmt, wd, ht, $urandom_range(0, 3) == 0);
      for (int k = 0; k < n; k++) begin
        send_pixel(pick_coord(cur_width), pick_coord(cur_height), 1'b0, '0);
        sent++;
      end
      phase_no++;
    end
    calm = 1'b0;

    wait_idle();
    if (mismatches == 0)
      $display("color_bar_pattern_generator_unit test passed");
    else
      $display("color_bar_pattern_generator_unit test failed");
    $finish;
  end

endmodule
